// ===== src/sliding_window_average_top_defines.svh =====
// ----------------------------------------------------------------------------
// Sliding window average - assertion macros
// Shared concurrent assertion forms, clocked on the rising edge with an
// active-low reset disable.
// ----------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_AVERAGE_TOP_DEFINES_SVH
`define SLIDING_WINDOW_AVERAGE_TOP_DEFINES_SVH

// same-cycle implication
`define SWA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SWA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/swa_pkg.sv =====
// ----------------------------------------------------------------------------
// swa_pkg - sliding window average shared definitions
// Field widths, fixed constants and the controller/datapath interface types.
// ----------------------------------------------------------------------------
package swa_pkg;

    localparam int SAMPLE_W    = 32;                 // Q24.8 sample and mean
    localparam int WIN_W       = 5;                  // window length / count
    localparam int WIN_RESET   = 16;
    localparam int WIN_MAX_CODE = (1 << WIN_W) - 1;
    localparam int SUM_W       = SAMPLE_W + WIN_W;   // exact sum of up to 31 samples
    localparam int DIV_CNT_W   = $clog2(SUM_W + 1);
    localparam int OUT_DATA_W  = ((SAMPLE_W + WIN_W + 7) / 8) * 8;

    typedef struct packed {
        logic accept;     // input transaction taken
        logic update;     // ring write, sum and count update
        logic div_start;  // load divider from the running sum
        logic out_load;   // move quotient into the output register
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_free;   // output register empty or being drained
    } t_status;

endpackage

// ===== src/swa_div.sv =====
// ----------------------------------------------------------------------------
// swa_div - signed by unsigned restoring divider
// One quotient bit per cycle over the magnitude of the sum; the sign is
// applied afterwards so the quotient truncates toward zero.
// ----------------------------------------------------------------------------
module swa_div
    import swa_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic signed [SUM_W-1:0]    i_dividend,
    input  logic        [WIN_W-1:0]    i_divisor,
    output logic                       o_busy,
    output logic signed [SAMPLE_W-1:0] o_quotient
);

    logic                 r_busy;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]     r_q;
    logic [WIN_W-1:0]     r_rem;
    logic [WIN_W-1:0]     r_div;
    logic                 r_neg;

    logic [WIN_W:0]       trial;
    logic                 ge;
    logic [WIN_W:0]       rem_sub;
    logic [SUM_W-1:0]     q_signed;

    assign trial   = {r_rem, r_q[SUM_W-1]};
    assign ge      = trial >= {1'b0, r_div};
    assign rem_sub = trial - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DIV_CNT_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SUM_W-1];
            r_q   <= i_dividend[SUM_W-1] ? (~i_dividend + SUM_W'(1)) : i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[WIN_W-1:0] : trial[WIN_W-1:0];
            r_q   <= {r_q[SUM_W-2:0], ge};
        end
    end

    assign q_signed   = r_neg ? (~r_q + SUM_W'(1)) : r_q;
    assign o_quotient = q_signed[SAMPLE_W-1:0];
    assign o_busy     = r_busy;

endmodule

// ===== src/swa_ctrl.sv =====
// ----------------------------------------------------------------------------
// swa_ctrl - sliding window average controller
// Sequences one item at a time: take, update window, divide, hand off.
// ----------------------------------------------------------------------------
module swa_ctrl
    import swa_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIV    = 4'b0100,
        ST_DONE   = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_in_ready      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                // the divider starts in the cycle after the update
                o_cmd.update    = 1'b1;
                o_cmd.div_start = 1'b1;
                n_state         = ST_DIV;
            end
            ST_DIV: begin
                // first cycle here loads the divider from the updated sum
                if (!i_status.div_busy) begin
                    if (i_status.out_free) begin
                        o_cmd.out_load = 1'b1;
                        n_state        = ST_IDLE;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/swa_dp.sv =====
// ----------------------------------------------------------------------------
// swa_dp - sliding window average datapath
// Window register, sample ring, running sum and count, divider and the
// output register.
// ----------------------------------------------------------------------------
module swa_dp
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [WIN_W-1:0]           i_cfg_wdata,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  t_cmd                       i_cmd,
    output t_status                    o_status,
    input  logic                       i_out_ready,
    output logic                       o_out_valid,
    output logic signed [SAMPLE_W-1:0] o_mean,
    output logic [WIN_W-1:0]           o_held
);

    localparam int SLOT_W    = $clog2(MAX_WINDOW);
    localparam int CMP_W     = (SLOT_W + 1 > WIN_W) ? SLOT_W + 1 : WIN_W;
    localparam int WIN_LIMIT = (MAX_WINDOW > WIN_MAX_CODE) ? WIN_MAX_CODE : MAX_WINDOW;
    localparam logic [WIN_W-1:0] WIN_LIMIT_V = WIN_W'(WIN_LIMIT);
    localparam logic [WIN_W-1:0] WIN_RESET_V =
        (WIN_LIMIT < WIN_RESET) ? WIN_W'(WIN_LIMIT) : WIN_W'(WIN_RESET);

    logic signed [SAMPLE_W-1:0] r_ring [MAX_WINDOW];

    logic [WIN_W-1:0]           r_window;
    logic [WIN_W-1:0]           n_window;
    logic [SLOT_W-1:0]          r_slot;
    logic [SLOT_W-1:0]          n_slot;
    logic [WIN_W-1:0]           r_held;
    logic [WIN_W-1:0]           n_held;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SAMPLE_W-1:0] r_old;
    logic                       r_div_go;
    logic                       r_out_valid;
    logic signed [SAMPLE_W-1:0] r_mean;
    logic [WIN_W-1:0]           r_out_held;

    logic                       full;
    logic [CMP_W-1:0]           slot_inc;
    logic                       div_busy;
    logic signed [SAMPLE_W-1:0] quotient;

    // clamp the written window length to 1..limit
    always_comb begin
        if (i_cfg_wdata == '0) begin
            n_window = WIN_W'(1);
        end else if (i_cfg_wdata > WIN_LIMIT_V) begin
            n_window = WIN_LIMIT_V;
        end else begin
            n_window = i_cfg_wdata;
        end
    end

    assign full     = r_held >= r_window;
    assign slot_inc = {{(CMP_W - SLOT_W){1'b0}}, r_slot} + CMP_W'(1);

    always_comb begin
        n_held = full ? r_window : r_held + WIN_W'(1);
        n_sum  = r_sum + SUM_W'(r_sample) - (full ? SUM_W'(r_old) : SUM_W'(0));
        if (slot_inc >= CMP_W'(r_window)) begin
            n_slot = '0;
        end else begin
            n_slot = slot_inc[SLOT_W-1:0];
        end
    end

    // sample ring: oldest entry read on accept, new sample written on update
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_old    <= r_ring[r_slot];
            r_sample <= i_sample;
        end
        if (i_cmd.update) begin
            r_ring[r_slot] <= r_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WIN_RESET_V;
            r_slot   <= '0;
            r_held   <= '0;
            r_sum    <= '0;
            r_div_go <= 1'b0;
        end else begin
            r_div_go <= i_cmd.div_start;
            if (i_cfg_we) begin
                r_window <= n_window;
                r_slot   <= '0;
                r_held   <= '0;
                r_sum    <= '0;
            end else if (i_cmd.update) begin
                r_slot <= n_slot;
                r_held <= n_held;
                r_sum  <= n_sum;
            end
        end
    end

    swa_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (r_held),
        .o_busy     (div_busy),
        .o_quotient (quotient)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean     <= quotient;
            r_out_held <= r_held;
        end
    end

    // divider reads busy in the cycle after start, so cover the start cycle too
    assign o_status.div_busy = div_busy || r_div_go;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_mean            = r_mean;
    assign o_held            = r_out_held;

endmodule

// ===== src/sliding_window_average_top.sv =====
// An input transaction is taken, the window is updated, the divider runs, and the
// quotient is moved into the output register; no new item is taken before that.
// The bit-serial divider makes one quotient bit per cycle over the 37-bit running sum.
// A finished result waits in the output register while the next item is taken.
// Reset (synchronous, active low) sets the window length to 16 (or MAX_WINDOW if
// lower) and empties the window; the sample ring itself is not cleared.
// ----------------------------------------------------------------------------
// sliding_window_average_top - moving average over signed Q24.8 samples
// Ring of the newest samples, exact running sum and truncating mean.
// ----------------------------------------------------------------------------
`include "sliding_window_average_top_defines.svh"

module sliding_window_average_top
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WIN_W-1:0]      i_cfg_wdata,     // window_length
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [SAMPLE_W-1:0]   s_axis_tdata,    // [31:0] sample
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata     // [31:0] mean, [36:32] samples_held
);

    t_cmd                       cmd;
    t_status                    status;
    logic signed [SAMPLE_W-1:0] mean;
    logic [WIN_W-1:0]           held;

    swa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    swa_dp #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (s_axis_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_mean      (mean),
        .o_held      (held)
    );

    assign m_axis_tdata = {{(OUT_DATA_W - SAMPLE_W - WIN_W){1'b0}}, held, mean};

    `SWA_ASSERT_NXT(a_one_item, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input taken while an item is in flight")
    `SWA_ASSERT_IMP(a_out_load_free, i_clk, i_rst_n, cmd.out_load, !m_axis_tvalid || m_axis_tready, "result overwrote a pending output")
    `SWA_ASSERT_NXT(a_div_started, i_clk, i_rst_n, cmd.update, status.div_busy, "divider not busy after window update")
    `SWA_ASSERT_IMP(a_held_nonzero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[36:32] != 5'd0, "result with zero samples held")

endmodule

// ===== sim/sliding_window_average_checker.sv =====
// ----------------------------------------------------------------------------
// sliding_window_average_checker - moving average scoreboard
// Watches the config port and both stream channels. Each accepted sample is
// run through a local ring/sum/count model that works out the expected mean
// and count. Each accepted output transaction is compared with the oldest
// expected result.
// ----------------------------------------------------------------------------
module sliding_window_average_checker
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [WIN_W-1:0]      i_cfg_wdata,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  logic [SAMPLE_W-1:0]   i_in_data,     // [31:0] sample
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  logic [OUT_DATA_W-1:0] i_out_data,    // [31:0] mean, [36:32] samples_held
    output int                    o_fail_count,
    output int                    o_pending
);

    localparam int SLOT_W = $clog2(MAX_WINDOW);

    typedef struct packed {
        logic [SAMPLE_W-1:0] mean;
        logic [WIN_W-1:0]    held;
    } t_avg_result;

    t_avg_result expected_avg_q[$];

    // local copy of the averaging state
    logic [SAMPLE_W-1:0] sample_ring [MAX_WINDOW];
    int unsigned         ring_slot;
    logic [WIN_W-1:0]    window_len;
    logic [WIN_W-1:0]    held_cnt;
    longint              window_sum;

    task automatic report_mismatch(input string what, input longint exp_v, input longint got_v);
        o_fail_count++;
        $display("[%0t] MISMATCH %s: expected %0d, got %0d", $time, what, exp_v, got_v);
    endtask

    always @(posedge i_clk) begin
        t_avg_result exp_r;
        longint      divisor;
        longint      quot;
        if (!i_rst_n) begin
            o_fail_count = 0;
            window_len   = WIN_W'(WIN_RESET);
            held_cnt     = '0;
            window_sum   = 0;
            ring_slot    = 0;
            expected_avg_q.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_wdata == 0)
                    window_len = WIN_W'(1);
                else if (i_cfg_wdata > MAX_WINDOW)
                    window_len = WIN_W'(MAX_WINDOW);
                else
                    window_len = i_cfg_wdata;
                held_cnt   = '0;
                window_sum = 0;
                ring_slot  = 0;
            end

            if (i_in_valid && i_in_ready) begin
                if (ring_slot >= window_len)
                    ring_slot = 0;
                // full window: oldest sample sits at the write slot
                if (held_cnt >= window_len) begin
                    window_sum = window_sum -
                                 longint'($signed(sample_ring[ring_slot[SLOT_W-1:0]]));
                    held_cnt   = window_len;
                end else begin
                    held_cnt = held_cnt + 1'b1;
                end
                sample_ring[ring_slot[SLOT_W-1:0]] = i_in_data;
                window_sum = window_sum + longint'($signed(i_in_data));
                ring_slot++;
                if (ring_slot >= window_len)
                    ring_slot = 0;
                divisor = longint'(held_cnt);
                quot    = window_sum / divisor;   // truncates toward zero
                exp_r.mean = quot[SAMPLE_W-1:0];
                exp_r.held = held_cnt;
                expected_avg_q.push_back(exp_r);
            end

            if (i_out_valid && i_out_ready) begin
                if (expected_avg_q.size() == 0) begin
                    report_mismatch("unexpected result, mean",
                                    0, longint'($signed(i_out_data[SAMPLE_W-1:0])));
                end else begin
                    exp_r = expected_avg_q[0];
                    expected_avg_q.delete(0);
                    if (i_out_data[SAMPLE_W-1:0] !== exp_r.mean)
                        report_mismatch("mean", longint'($signed(exp_r.mean)),
                                        longint'($signed(i_out_data[SAMPLE_W-1:0])));
                    if (i_out_data[SAMPLE_W +: WIN_W] !== exp_r.held)
                        report_mismatch("samples_held", longint'(exp_r.held),
                                        longint'(i_out_data[SAMPLE_W +: WIN_W]));
                end
            end
        end
        o_pending = expected_avg_q.size();
    end

endmodule

// ===== sim/tb_sliding_window_average_top.sv =====
// ----------------------------------------------------------------------------
// tb_sliding_window_average_top - moving average testbench
// Drives directed and random Q24.8 samples through several window lengths,
// with bursty input traffic and output back-pressure. Checking is done by
// the scoreboard module next to the block.
// ----------------------------------------------------------------------------
module tb_sliding_window_average_top;
    import swa_pkg::*;

    localparam int     RANDOM_ITEMS = 1550;
    localparam longint CYCLE_LIMIT  = 1000000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [WIN_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [SAMPLE_W-1:0]   s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    int     fail_count;
    int     pending;
    longint cycle_cnt = 0;
    int     burst_left = 0;

    // output back-pressure state
    int rx_mode = 0;
    int rx_mode_left = 0;
    int rx_hold = 0;

    sliding_window_average_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sliding_window_average_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_in_valid   (s_axis_tvalid),
        .i_in_ready   (s_axis_tready),
        .i_in_data    (s_axis_tdata),
        .i_out_valid  (m_axis_tvalid),
        .i_out_ready  (m_axis_tready),
        .i_out_data   (m_axis_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // receiver: always ready, coin-flip, or long stalls, switching now and then
    always @(posedge i_clk) begin
        if (rx_mode_left == 0) begin
            rx_mode      <= $urandom_range(0, 2);
            rx_mode_left <= $urandom_range(100, 800);
        end else begin
            rx_mode_left <= rx_mode_left - 1;
        end
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: begin
                if (rx_hold > 0) begin
                    rx_hold       <= rx_hold - 1;
                    m_axis_tready <= 1'b0;
                end else begin
                    rx_hold       <= $urandom_range(0, 64);
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // one input transaction, then maybe a gap once the burst is used up
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 15);
            gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WIN_W-1:0] wl);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= wl;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    initial begin
        int               sent;
        int               phase_items;
        logic [WIN_W-1:0] wl;
        logic [SAMPLE_W-1:0] smp;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset window of 16, extreme samples
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'h8000_0000);
        push_sample(32'hFFFF_FFFF);
        // zero length is taken as one
        write_window(5'd0);
        push_sample(32'h8000_0000);
        push_sample(32'h7FFF_FFFF);
        push_sample(32'd5);
        // over-range length saturates to 16
        write_window(5'd31);
        push_sample(32'h8000_0000);
        push_sample(32'h8000_0000);
        push_sample(32'd1);
        // short window: negative truncation and wrap-around
        write_window(5'd3);
        push_sample(-7);
        push_sample(-1);
        push_sample(0);
        push_sample(100);
        push_sample(32'h7FFF_FFFF);
        write_window(5'd2);
        push_sample(3);
        push_sample(-4);
        push_sample(1);

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 9))
                0:       wl = 5'd0;
                1:       wl = 5'd1;
                2:       wl = 5'd16;
                3:       wl = WIN_W'($urandom_range(17, 31));
                default: wl = WIN_W'($urandom_range(2, 16));
            endcase
            write_window(wl);
            phase_items = $urandom_range(1, 80);
            for (int k = 0; k < phase_items && sent < RANDOM_ITEMS; k++) begin
                case ($urandom_range(0, 7))
                    0: smp = 32'h7FFF_FFFF;
                    1: smp = 32'h8000_0000;
                    2: smp = ($urandom_range(0, 1) == 0) ? 32'h0 : 32'hFFFF_FFFF;
                    3, 4: smp = $urandom_range(0, 2000) - 1000;
                    default: smp = $urandom;
                endcase
                push_sample(smp);
                sent++;
            end
        end

        wait_drained();
        repeat (60) @(posedge i_clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
